// ----- rtl/wacal_pkg.sv -----
// ============================================================================
// Windowed ADC average and calibration package
// Shared widths, register indexes, state encoding and link types.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package wacal_pkg;

    localparam int DATA_W    = 16;
    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = 5;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_RAW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_OUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_RAW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_OUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP    = 3'd4;

    localparam logic [DATA_W-1:0] DATA_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_AVG,
        S_MAP,
        S_CAL,
        S_CDIV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic              done;
        logic              filled;
        logic [DATA_W-1:0] min;
        logic [DATA_W-1:0] max;
    } win_stat_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/wacal_window.sv -----
// ============================================================================
// Window store and walk
// Ring memory of samples; a walk over all entries gives sum, minimum, maximum.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module wacal_window
    import wacal_pkg::*;
#(
    parameter int WINDOW_SIZE = 16
)(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic [DATA_W-1:0]                       sample,
    output logic [$clog2(WINDOW_SIZE)+DATA_W-1:0]   sum,
    output win_stat_t                               stat
);

    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int SW = AW + DATA_W;
    localparam logic [AW-1:0] LAST = AW'(WINDOW_SIZE - 1);

    logic [DATA_W-1:0] mem [WINDOW_SIZE];
    logic [DATA_W-1:0] rd_data_reg;

    logic [AW-1:0]     wptr_reg;
    logic              filled_reg;
    logic              busy_reg;
    logic [AW-1:0]     rd_idx_reg;
    logic              rd_vld_reg;
    logic              rd_ok_reg;
    logic              rd_last_reg;
    logic              done_reg;

    logic [SW-1:0]     sum_reg;
    logic [DATA_W-1:0] min_reg;
    logic [DATA_W-1:0] max_reg;
    logic [DATA_W-1:0] entry;

    // Entries not yet written since reset read as zero.
    assign entry = rd_ok_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mem[wptr_reg] <= sample;
        end
        rd_data_reg <= mem[rd_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg    <= '0;
            filled_reg  <= 1'b0;
            busy_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            rd_ok_reg   <= 1'b0;
            rd_last_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rd_vld_reg  <= busy_reg;
            rd_ok_reg   <= filled_reg || (rd_idx_reg < wptr_reg);
            rd_last_reg <= busy_reg && (rd_idx_reg == LAST);
            done_reg    <= rd_vld_reg && rd_last_reg;
            if (start)
            begin
                if (wptr_reg == LAST)
                begin
                    wptr_reg   <= '0;
                    filled_reg <= 1'b1;
                end
                else
                begin
                    wptr_reg <= wptr_reg + 1'b1;
                end
                busy_reg   <= 1'b1;
                rd_idx_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (rd_idx_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= '0;
            min_reg <= DATA_MAX;
            max_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            sum_reg <= sum_reg + SW'(entry);
            if (entry < min_reg)
            begin
                min_reg <= entry;
            end
            if (entry > max_reg)
            begin
                max_reg <= entry;
            end
        end
    end

    assign sum         = sum_reg;
    assign stat.done   = done_reg;
    assign stat.filled = filled_reg;
    assign stat.min    = min_reg;
    assign stat.max    = max_reg;

endmodule

`default_nettype wire

// ----- rtl/wacal_div.sv -----
// ============================================================================
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module wacal_div
    import wacal_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     quo_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DATA_W:0]      shifted;
    logic [DATA_W+1:0]    diff;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W+1])
            begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DATA_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ----- rtl/windowed_adc_average_calibrate_unit.sv -----
// ============================================================================
// Windowed ADC average and calibration unit
// Moving average, window minimum and maximum, and linear calibration.
// ============================================================================
// Samples arrive on the sample channel and results leave on the result
// channel, both with valid/ready handshakes. Each sample transfer is
// written into a ring memory of WINDOW_SIZE entries and produces exactly
// one result transfer carrying average, window_min, window_max and
// calibrated. The five calibration registers are written through the
// cfg_we/cfg_index/cfg_data port; they must be written only while the unit
// is idle, which the unit itself does not enforce. One sample is processed
// at a time. The memory is walked entry by entry, the window average is a
// multiplication by a reciprocal, and the calibration divider produces one
// quotient bit per cycle. Before the window has filled the averaging step
// is skipped, and with a zero raw span the divider is skipped. The next
// sample is taken once a result is loaded into the output register.
// Reset clears the pointer and fill flag, so unwritten entries read as zero,
// and loads the registers with their reset values. A finished result waits
// in the output register while the receiver stalls; a new sample may be
// taken meanwhile, but the next result waits for the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module windowed_adc_average_calibrate_unit
    import wacal_pkg::*;
#(
    parameter int WINDOW_SIZE = 16
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    input  logic [DATA_W-1:0]    sample,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic [DATA_W-1:0]    average,
    output logic [DATA_W-1:0]    window_min,
    output logic [DATA_W-1:0]    window_max,
    output logic [DATA_W-1:0]    calibrated
);

    localparam int AW  = $clog2(WINDOW_SIZE);
    localparam int SW  = AW + DATA_W;
    localparam int RSH = SW + AW;
    localparam int PW  = 2*DATA_W + 2;

    // The window sum is divided by WINDOW_SIZE through a multiplication by
    // its rounded-up reciprocal, which is exact over the whole sum range.
    localparam logic [SW:0] RECIP =
        (SW+1)'(((64'd1 << RSH) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));

    state_t               state_reg, state_next;

    logic [DATA_W-1:0]    low_raw_reg;
    logic [DATA_W-1:0]    low_out_reg;
    logic [DATA_W-1:0]    high_raw_reg;
    logic [DATA_W-1:0]    high_out_reg;
    logic                 clamp_reg;

    logic [DATA_W-1:0]    sample_reg, sample_next;
    logic [DATA_W-1:0]    min_reg, min_next;
    logic [DATA_W-1:0]    max_reg, max_next;
    logic [DATA_W-1:0]    avg_reg, avg_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic                 neg_reg, neg_next;
    logic [DATA_W-1:0]    cal_reg, cal_next;

    logic                 result_valid_reg, result_valid_next;
    logic [DATA_W-1:0]    average_reg, average_next;
    logic [DATA_W-1:0]    wmin_reg, wmin_next;
    logic [DATA_W-1:0]    wmax_reg, wmax_next;
    logic [DATA_W-1:0]    calibrated_reg, calibrated_next;

    logic                 win_start;
    logic [SW-1:0]        win_sum;
    win_stat_t            win_stat;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic [2*SW:0]            avg_prod;
    logic [DATA_W-1:0]        x_clamped;
    logic signed [DATA_W:0]   x_diff;
    logic signed [DATA_W:0]   rise;
    logic signed [DATA_W:0]   run;
    logic [DATA_W:0]          run_neg;
    logic [DATA_W-1:0]        run_mag;
    logic [PW-1:0]            prod_neg;
    logic [DIV_W-1:0]         prod_mag;
    logic [DATA_W-1:0]        q_low;
    logic [DATA_W-1:0]        q_signed;

    wacal_window #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (win_start),
        .sample (sample),
        .sum    (win_sum),
        .stat   (win_stat)
    );

    wacal_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        x_clamped = avg_reg;
        if (clamp_reg)
        begin
            if (avg_reg < low_raw_reg)
            begin
                x_clamped = low_raw_reg;
            end
            else if (avg_reg > high_raw_reg)
            begin
                x_clamped = high_raw_reg;
            end
        end
    end

    assign avg_prod = (2*SW+1)'(win_sum) * (2*SW+1)'(RECIP);
    assign x_diff   = $signed({1'b0, x_clamped}) - $signed({1'b0, low_raw_reg});
    assign rise     = $signed({1'b0, high_out_reg}) - $signed({1'b0, low_out_reg});
    assign run      = $signed({1'b0, high_raw_reg}) - $signed({1'b0, low_raw_reg});
    assign run_neg  = -run;
    assign run_mag  = run[DATA_W] ? run_neg[DATA_W-1:0] : run[DATA_W-1:0];
    assign prod_neg = -prod_reg;
    assign prod_mag = prod_reg[PW-1] ? prod_neg[DIV_W-1:0] : prod_reg[DIV_W-1:0];
    assign q_low    = div_rsp.quotient[DATA_W-1:0];
    assign q_signed = neg_reg ? (~q_low + 1'b1) : q_low;

    always_comb
    begin
        state_next        = state_reg;
        sample_next       = sample_reg;
        min_next          = min_reg;
        max_next          = max_reg;
        avg_next          = avg_reg;
        prod_next         = prod_reg;
        neg_next          = neg_reg;
        cal_next          = cal_reg;
        result_valid_next = result_valid_reg && !result_ready;
        average_next      = average_reg;
        wmin_next         = wmin_reg;
        wmax_next         = wmax_reg;
        calibrated_next   = calibrated_reg;
        win_start         = 1'b0;
        div_req.start     = 1'b0;
        div_req.dividend  = prod_mag;
        div_req.divisor   = run_mag;
        sample_ready      = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    win_start   = 1'b1;
                    sample_next = sample;
                    state_next  = S_WALK;
                end
            end
            S_WALK:
            begin
                if (win_stat.done)
                begin
                    min_next = win_stat.min;
                    max_next = win_stat.max;
                    if (win_stat.filled)
                    begin
                        state_next = S_AVG;
                    end
                    else
                    begin
                        avg_next   = sample_reg;
                        state_next = S_MAP;
                    end
                end
            end
            S_AVG:
            begin
                avg_next   = avg_prod[RSH +: DATA_W];
                state_next = S_MAP;
            end
            S_MAP:
            begin
                prod_next  = PW'(x_diff) * PW'(rise);
                state_next = S_CAL;
            end
            S_CAL:
            begin
                if (run == '0)
                begin
                    cal_next   = low_out_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    neg_next      = prod_reg[PW-1] ^ run[DATA_W];
                    state_next    = S_CDIV;
                end
            end
            S_CDIV:
            begin
                if (div_rsp.done)
                begin
                    cal_next   = q_signed + low_out_reg;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_valid_next = 1'b1;
                    average_next      = avg_reg;
                    wmin_next         = min_reg;
                    wmax_next         = max_reg;
                    calibrated_next   = cal_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            low_raw_reg      <= '0;
            low_out_reg      <= '0;
            high_raw_reg     <= DATA_MAX;
            high_out_reg     <= DATA_MAX;
            clamp_reg        <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOW_RAW:  low_raw_reg  <= cfg_data;
                    CFG_LOW_OUT:  low_out_reg  <= cfg_data;
                    CFG_HIGH_RAW: high_raw_reg <= cfg_data;
                    CFG_HIGH_OUT: high_out_reg <= cfg_data;
                    CFG_CLAMP:    clamp_reg    <= cfg_data[0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg     <= sample_next;
        min_reg        <= min_next;
        max_reg        <= max_next;
        avg_reg        <= avg_next;
        prod_reg       <= prod_next;
        neg_reg        <= neg_next;
        cal_reg        <= cal_next;
        average_reg    <= average_next;
        wmin_reg       <= wmin_next;
        wmax_reg       <= wmax_next;
        calibrated_reg <= calibrated_next;
    end

    assign result_valid = result_valid_reg;
    assign average      = average_reg;
    assign window_min   = wmin_reg;
    assign window_max   = wmax_reg;
    assign calibrated   = calibrated_reg;

endmodule

`default_nettype wire

// ----- tb/tb_windowed_adc_average_calibrate_unit.sv -----
// ============================================================================
// Windowed ADC average and calibration unit testbench
// Sends converter samples with random gaps, stalls the result channel at
// random (neither while streaming) and compares average, window minimum,
// window maximum and the calibrated value against a local model of the
// window and linear map. Calibration settings are rewritten while idle.
// ============================================================================
`timescale 1ns / 1ps

module tb_windowed_adc_average_calibrate_unit;
    import wacal_pkg::*;

    localparam int WIN_DEPTH = 16;
    localparam int MAX_REPORTS = 50;

    typedef struct packed {
        logic [DATA_W-1:0] average;
        logic [DATA_W-1:0] lowest;
        logic [DATA_W-1:0] highest;
        logic [DATA_W-1:0] calibrated;
    } stats_t;

    typedef enum int {
        PAT_UNIFORM,
        PAT_LEVEL,
        PAT_RAILS,
        PAT_SPAN_EDGE
    } pattern_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 sample_valid;
    logic                 sample_ready;
    logic [DATA_W-1:0]    sample;
    logic                 result_valid;
    logic                 result_ready;
    logic [DATA_W-1:0]    average;
    logic [DATA_W-1:0]    window_min;
    logic [DATA_W-1:0]    window_max;
    logic [DATA_W-1:0]    calibrated;

    logic [DATA_W-1:0] win_mem [WIN_DEPTH];
    int unsigned       wr_ptr;
    bit                win_full;
    logic [DATA_W-1:0] cal_low_raw;
    logic [DATA_W-1:0] cal_low_out;
    logic [DATA_W-1:0] cal_high_raw;
    logic [DATA_W-1:0] cal_high_out;
    bit                cal_clamp;

    stats_t expected_stats [$];
    int     mismatch_count;
    bit     idle_on;
    int     stall_left;

    windowed_adc_average_calibrate_unit #(
        .WINDOW_SIZE (WIN_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .average      (average),
        .window_min   (window_min),
        .window_max   (window_max),
        .calibrated   (calibrated)
    );

    always #5 clk = ~clk;

    function automatic logic [DATA_W-1:0] map_to_output(input logic [DATA_W-1:0] avg);
        longint x;
        longint lr;
        longint lo;
        longint hr;
        longint ho;
        longint v;
        x  = avg;
        lr = cal_low_raw;
        lo = cal_low_out;
        hr = cal_high_raw;
        ho = cal_high_out;
        if (cal_clamp)
        begin
            if (x < lr)
                x = lr;
            else if (x > hr)
                x = hr;
        end
        if (hr == lr)
            return cal_low_out;
        v = (x - lr) * (ho - lo) / (hr - lr) + lo;
        return v[DATA_W-1:0];
    endfunction

    function automatic stats_t predict_stats(input logic [DATA_W-1:0] value);
        stats_t      r;
        int unsigned sum;
        win_mem[wr_ptr] = value;
        wr_ptr++;
        if (wr_ptr == WIN_DEPTH)
        begin
            wr_ptr   = 0;
            win_full = 1'b1;
        end
        sum       = 0;
        r.lowest  = DATA_MAX;
        r.highest = '0;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            sum += win_mem[i];
            if (win_mem[i] < r.lowest)
                r.lowest = win_mem[i];
            if (win_mem[i] > r.highest)
                r.highest = win_mem[i];
        end
        r.average    = win_full ? DATA_W'(sum / WIN_DEPTH) : value;
        r.calibrated = map_to_output(r.average);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] exp_val,
                               input logic [DATA_W-1:0] act_val);
        if (act_val !== exp_val)
        begin
            if (mismatch_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h",
                         $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        stats_t exp_stats;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_stats.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual %h %h %h %h",
                             $time, average, window_min, window_max, calibrated);
                mismatch_count++;
            end
            else
            begin
                exp_stats = expected_stats.pop_front();
                check_field("average", exp_stats.average, average);
                check_field("window_min", exp_stats.lowest, window_min);
                check_field("window_max", exp_stats.highest, window_max);
                check_field("calibrated", exp_stats.calibrated, calibrated);
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_left == 0 && idle_on && rst_n && $urandom_range(0, 15) == 0)
            stall_left = $urandom_range(1, 19);
        if (stall_left > 0)
        begin
            stall_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= 1'b1;
    end

    task automatic send_sample(input logic [DATA_W-1:0] value);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= value;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        expected_stats.push_back(predict_stats(value));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (expected_stats.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_LOW_RAW:  cal_low_raw  = value;
            CFG_LOW_OUT:  cal_low_out  = value;
            CFG_HIGH_RAW: cal_high_raw = value;
            CFG_HIGH_OUT: cal_high_out = value;
            CFG_CLAMP:    cal_clamp    = value[0];
            default:      ;
        endcase
        @(negedge clk);
    endtask

    task automatic program_span(input logic [DATA_W-1:0] low_raw, input logic [DATA_W-1:0] low_out,
                                input logic [DATA_W-1:0] high_raw,
                                input logic [DATA_W-1:0] high_out,
                                input logic [DATA_W-1:0] clamp_word, input bit with_unused);
        wait_idle();
        write_reg(CFG_LOW_RAW, low_raw);
        write_reg(CFG_LOW_OUT, low_out);
        if (with_unused)
            write_reg(CFG_IDX_W'($urandom_range(CFG_CLAMP + 1, (1 << CFG_IDX_W) - 1)),
                      DATA_W'($urandom));
        write_reg(CFG_HIGH_RAW, high_raw);
        write_reg(CFG_HIGH_OUT, high_out);
        write_reg(CFG_CLAMP, clamp_word);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_point();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return DATA_MAX;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_pattern(input int count);
        int                left;
        int                run;
        pattern_t          mode;
        logic [DATA_W-1:0] level;
        logic [DATA_W-1:0] value;
        left = count;
        while (left > 0)
        begin
            mode  = pattern_t'($urandom_range(0, 3));
            level = pick_point();
            run   = $urandom_range(4, 40);
            if (run > left)
                run = left;
            repeat (run)
            begin
                case (mode)
                    PAT_UNIFORM:
                        value = DATA_W'($urandom);
                    PAT_LEVEL:
                        value = (level > DATA_MAX - 16) ? level - DATA_W'($urandom_range(0, 15))
                                                        : level + DATA_W'($urandom_range(0, 15));
                    PAT_RAILS:
                        value = $urandom_range(0, 1) ? DATA_MAX : '0;
                    default:
                        value = ($urandom_range(0, 1) ? cal_low_raw : cal_high_raw)
                                ^ DATA_W'($urandom_range(0, 3));
                endcase
                send_sample(value);
            end
            left -= run;
        end
    endtask

    // The window is still filling here, so the average equals the sample.
    task automatic test_calibration_corners();
        send_sample(DATA_MAX);
        send_sample('0);
        program_span(DATA_MAX, '0, '0, DATA_MAX, '0, 1'b0);
        send_sample(16'h1234);
        program_span(16'hC000, 16'h0100, 16'h4000, 16'hF000, DATA_MAX, 1'b0);
        send_sample(16'h1000);
        send_sample(16'hE000);
        send_sample(16'h8000);
        program_span(16'h1000, DATA_MAX, 16'hF000, '0, 16'h0001, 1'b0);
        send_sample('0);
        send_sample(DATA_MAX);
        send_sample(16'h8000);
        program_span(16'h1000, 16'h0010, 16'hF000, 16'hFFF0, 16'hFFFE, 1'b1);
        send_sample('0);
        program_span(16'h7777, 16'hABCD, 16'h7777, 16'h0123, 16'h5555, 1'b0);
        send_sample(16'h7777);
        send_sample('0);
    endtask

    task automatic test_window_fill();
        program_span('0, '0, DATA_MAX, DATA_MAX, '0, 1'b1);
        send_sample(DATA_MAX);
        send_sample(16'h0001);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(DATA_MAX);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
    endtask

    task automatic test_random_settings();
        logic [DATA_W-1:0] low_raw;
        for (int phase = 0; phase < 20; phase++)
        begin
            low_raw = pick_point();
            program_span(low_raw, pick_point(),
                         ($urandom_range(0, 5) == 0) ? low_raw : pick_point(),
                         pick_point(), DATA_W'($urandom), $urandom_range(0, 1));
            send_pattern(60);
        end
    endtask

    task automatic test_streaming();
        program_span(pick_point(), pick_point(), pick_point(), pick_point(),
                     DATA_W'($urandom), 1'b0);
        idle_on = 1'b0;
        send_pattern(150);
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        sample_valid   = 1'b0;
        sample         = '0;
        result_ready   = 1'b0;
        stall_left     = 0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++)
            win_mem[i] = '0;
        wr_ptr       = 0;
        win_full     = 1'b0;
        cal_low_raw  = '0;
        cal_low_out  = '0;
        cal_high_raw = DATA_MAX;
        cal_high_out = DATA_MAX;
        cal_clamp    = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_calibration_corners();
        test_window_fill();
        test_random_settings();
        test_streaming();

        wait_idle();
        repeat (120) @(negedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
